// ===== rtl/rc4ke_pkg.sv =====
// shared types and constants for the rc4 keystream engine
// no dependencies; imported by every module of the block except rc4ke_ram
package rc4ke_pkg;

  localparam int KEY_MAX_DEF = 16;
  localparam int PERM_DEPTH  = 256;
  localparam logic [4:0] KEY_LEN_RST = 5'd16;
  localparam logic [7:0] PERM_LAST = 8'(PERM_DEPTH - 1);

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_SCHED = 3'd1,
    OP_BYTE  = 3'd2,
    OP_WORD  = 3'd3,
    OP_SKIP  = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  key_byte;
    logic [3:0]  key_index;
    logic        init_first;
    logic        reset_after;
    logic [15:0] skip_count;
  } req_t;

  typedef struct packed {
    logic [31:0] stream_value;
    logic        value_is_word;
  } res_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       key_we;
    logic       fill;
    logic [7:0] fill_idx;
    logic       zero_ij;
    logic       dec_i;
    logic       k_clear;
    logic       step_i;
    logic       step_j;
    logic       write_i;
    logic       write_j;
    logic       sched;
    logic       shift;
    logic       emit;
    logic       word;
  } ctl_t;

endpackage

// ===== rtl/rc4ke_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module rc4ke_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rc4ke_ctrl.sv =====
// sequencer for the rc4 engine: request decode, round and byte counting
// depends on rc4ke_pkg; drives the datapath through ctl_t
module rc4ke_ctrl import rc4ke_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t request,
  output logic busy,
  output ctl_t ctl
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_DEC,
    ST_RD_I,
    ST_RD_J,
    ST_WR_I,
    ST_WR_J
  } state_t;

  state_t      state;
  logic [15:0] cnt;
  logic        sched;
  logic        want_out;
  logic        is_word;
  logic        reset_after;
  logic        last;

  assign busy = (state != ST_IDLE);
  assign last = (cnt == 16'd0);

  always_comb begin
    ctl          = '0;
    ctl.key_we   = (state == ST_IDLE) && start && (request.opcode == OP_LOAD);
    ctl.fill     = (state == ST_FILL);
    ctl.fill_idx = cnt[7:0];
    ctl.zero_ij  = ((state == ST_FILL) && (cnt[7:0] == PERM_LAST)) ||
                   ((state == ST_WR_J) && sched && last && reset_after);
    ctl.dec_i    = (state == ST_DEC);
    ctl.k_clear  = (state == ST_DEC);
    ctl.step_i   = (state == ST_RD_I);
    ctl.step_j   = (state == ST_RD_J);
    ctl.write_i  = (state == ST_WR_I);
    ctl.write_j  = (state == ST_WR_J);
    ctl.sched    = sched;
    ctl.shift    = (state == ST_WR_J) && !sched;
    ctl.emit     = (state == ST_WR_J) && !sched && want_out && last;
    ctl.word     = is_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      sched       <= 1'b0;
      want_out    <= 1'b0;
      is_word     <= 1'b0;
      reset_after <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            priority case (request.opcode)
              OP_SCHED: begin
                sched       <= 1'b1;
                want_out    <= 1'b0;
                reset_after <= request.reset_after;
                cnt         <= '0;
                state       <= request.init_first ? ST_FILL : ST_DEC;
              end
              OP_BYTE: begin
                sched    <= 1'b0;
                want_out <= 1'b1;
                is_word  <= 1'b0;
                cnt      <= '0;
                state    <= ST_RD_I;
              end
              OP_WORD: begin
                sched    <= 1'b0;
                want_out <= 1'b1;
                is_word  <= 1'b1;
                cnt      <= 16'd3;
                state    <= ST_RD_I;
              end
              OP_SKIP: begin
                sched    <= 1'b0;
                want_out <= 1'b0;
                cnt      <= request.skip_count - 16'd1;
                if (request.skip_count != 16'd0) begin
                  state <= ST_RD_I;
                end
              end
              default: ;
            endcase
          end
        end
        ST_FILL: begin
          cnt <= cnt + 16'd1;
          if (cnt[7:0] == PERM_LAST) begin
            state <= ST_DEC;
          end
        end
        ST_DEC: begin
          cnt   <= 16'(PERM_DEPTH - 1);
          state <= ST_RD_I;
        end
        ST_RD_I: state <= ST_RD_J;
        ST_RD_J: state <= ST_WR_I;
        ST_WR_I: state <= ST_WR_J;
        ST_WR_J: begin
          if (last) begin
            state <= ST_IDLE;
          end else begin
            cnt   <= cnt - 16'd1;
            state <= ST_RD_I;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/rc4ke_dpath.sv =====
// datapath: indices, swap registers, permutation and key memories, result
// depends on rc4ke_pkg and rc4ke_ram
module rc4ke_dpath import rc4ke_pkg::*; #(
  parameter int KEY_MAX = KEY_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  req_t       request,
  input  ctl_t       ctl,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [4:0] cfg_data,
  output logic       result_valid,
  output res_t       result
);

  localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

  logic [7:0]    i, j, a, b, t;
  logic [23:0]   acc;
  logic [KW-1:0] k;
  logic [4:0]    key_length;

  logic [7:0]    perm_rdata, key_rdata;
  logic [7:0]    perm_raddr, perm_waddr, perm_wdata;
  logic          perm_we;
  logic [7:0]    i_inc, j_add, sum_ab, byte_val;
  logic [8:0]    key_len_eff, k_inc, kidx_ext;
  logic [KW-1:0] k_next;
  logic          key_we;

  assign i_inc  = i + 8'd1;
  assign j_add  = j + perm_rdata + (ctl.sched ? key_rdata : 8'd0);
  assign sum_ab = a + perm_rdata;
  // output entry read before the swap writes landed
  assign byte_val = (t == j) ? a : ((t == i) ? b : perm_rdata);

  always_comb begin
    if (key_length == 5'd0) begin
      key_len_eff = 9'd1;
    end else if (9'(key_length) > 9'(KEY_MAX)) begin
      key_len_eff = 9'(KEY_MAX);
    end else begin
      key_len_eff = 9'(key_length);
    end
  end

  assign k_inc  = 9'(k) + 9'd1;
  assign k_next = (k_inc >= key_len_eff) ? '0 : k_inc[KW-1:0];

  assign kidx_ext = 9'(request.key_index);
  assign key_we   = ctl.key_we && (kidx_ext < 9'(KEY_MAX));

  always_comb begin
    priority if (ctl.step_i) begin
      perm_raddr = i_inc;
    end else if (ctl.step_j) begin
      perm_raddr = j_add;
    end else begin
      perm_raddr = sum_ab;
    end
  end

  always_comb begin
    priority if (ctl.fill) begin
      perm_waddr = ctl.fill_idx;
      perm_wdata = ctl.fill_idx;
    end else if (ctl.write_i) begin
      perm_waddr = i;
      perm_wdata = perm_rdata;
    end else begin
      perm_waddr = j;
      perm_wdata = a;
    end
  end

  assign perm_we = ctl.fill || ctl.write_i || ctl.write_j;

  rc4ke_ram #(.WIDTH(8), .DEPTH(PERM_DEPTH)) u_perm (
    .clk   (clk),
    .we    (perm_we),
    .waddr (perm_waddr),
    .wdata (perm_wdata),
    .raddr (perm_raddr),
    .rdata (perm_rdata)
  );

  rc4ke_ram #(.WIDTH(8), .DEPTH(KEY_MAX)) u_key (
    .clk   (clk),
    .we    (key_we),
    .waddr (kidx_ext[KW-1:0]),
    .wdata (request.key_byte),
    .raddr (k),
    .rdata (key_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      i            <= '0;
      j            <= '0;
      key_length   <= KEY_LEN_RST;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        key_length <= cfg_data;
      end
      if (ctl.zero_ij) begin
        i <= '0;
        j <= '0;
      end else begin
        if (ctl.dec_i) begin
          i <= i - 8'd1;
        end else if (ctl.step_i) begin
          i <= i_inc;
        end
        if (ctl.step_j) begin
          j <= j_add;
        end
      end
      result_valid <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step_j) begin
      a <= perm_rdata;
    end
    if (ctl.write_i) begin
      b <= perm_rdata;
      t <= sum_ab;
    end
    if (ctl.k_clear) begin
      k <= '0;
    end else if (ctl.write_j && ctl.sched) begin
      k <= k_next;
    end
    if (ctl.shift) begin
      acc <= {acc[15:0], byte_val};
    end
    if (ctl.emit) begin
      result.stream_value  <= ctl.word ? {acc, byte_val} : {24'd0, byte_val};
      result.value_is_word <= ctl.word;
    end
  end

endmodule

// ===== rtl/rc4_keystream_engine.sv =====
// top level of the rc4 keystream engine: controller plus datapath
// depends on rc4ke_pkg, rc4ke_ctrl, rc4ke_dpath
//
// channel   signals                          direction  handshake
// request   start, busy, request (req_t)     in         start && !busy
// result    result_valid, result (res_t)     out        one-cycle strobe
// config    cfg_valid, cfg_ready, cfg_data   in         cfg_valid && cfg_ready
//
// each keystream byte runs the states rd_i, rd_j, wr_i, wr_j: three dependent reads and two
// swap writes share the one read and one write port of the permutation ram.
// get byte or word: result strobe in the cycle after the last busy cycle; a word packs four bytes.
// skip of n bytes: n byte steps with no result. load: never busy.
// schedule: identity fill when requested, then the dec state, then one swap step per entry.
// rst is synchronous; the permutation and key store are not cleared.
// results cannot be held off; a new request is taken in the strobe cycle.
module rc4_keystream_engine import rc4ke_pkg::*; #(
  parameter int KEY_MAX = KEY_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  req_t       request,
  output logic       result_valid,
  output res_t       result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

  ctl_t ctl;

  assign cfg_ready = 1'b1;

  rc4ke_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .ctl     (ctl)
  );

  rc4ke_dpath #(.KEY_MAX(KEY_MAX)) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .ctl          (ctl),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  // a result is always the last step of a busy stretch
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(busy) && !busy))
    else $error("result without preceding work");

  // a byte result keeps the upper bits clear
  a_byte_upper_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.value_is_word) |-> (result.stream_value[31:8] == 24'd0))
    else $error("byte result with upper bits set");

  // a key load never makes the block busy
  a_load_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (request.opcode == OP_LOAD)) |=> !busy)
    else $error("load request left the block busy");

  // accepting a request never produces a result in the next cycle
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !result_valid)
    else $error("result strobe directly after request");

endmodule
